@@ sv/ctc_pkg.sv @@
`default_nettype none

package ctc_pkg;

    // screen size defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // control and printable codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE   = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB         = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LINEFEED    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'h7F;

    localparam int TAB_STEP = 8;

    // one result word
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [CELL_W-1:0] write_data;
        logic              clear_screen;
        logic [ADDR_W-1:0] cursor_pos;
    } t_result;

endpackage

`default_nettype wire

@@ sv/text_console_cursor_writer.sv @@
`default_nettype none

// Text console cursor writer. Each character word in (8 bits) gives exactly
// one result word out, in the cycle after acceptance, and a new character is
// taken every cycle while the result register is empty or being drained.
// Printable bytes 0x20..0x7F write a cell (attribute high byte, character low
// byte) at row*COLUMNS+column; backspace, tab, carriage return and line feed
// only move the cursor; other bytes are ignored. Running off the bottom row
// raises clear_screen and homes the cursor. Result tuser: bit 0 write_valid,
// bit 1 clear_screen. The attribute register (reset 0x0F) should be written
// only while no result is pending.
module text_console_cursor_writer #(
    parameter int COLUMNS = ctc_pkg::COLUMNS_DEF,
    parameter int ROWS    = ctc_pkg::ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // attribute write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    // character in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    // result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [10:0] write_address, [26:11] write_data,
                                             // [37:27] cursor_pos, [39:38] zero
    output logic [1:0]       m_axis_tuser    // [0] write_valid, [1] clear_screen
);

    logic [ctc_pkg::ATTR_W-1:0] r_attr;
    logic                       fire;
    ctc_pkg::t_result           next_result;
    ctc_pkg::t_result           out_result;

    // attribute register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ctc_pkg::ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    assign fire = s_axis_tvalid && s_axis_tready;

    ctc_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_char   (s_axis_tdata),
        .i_attr   (r_attr),
        .o_result (next_result)
    );

    ctc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (next_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // pack the result word
    assign m_axis_tdata = {2'b00, out_result.cursor_pos,
                           out_result.write_data, out_result.write_address};
    assign m_axis_tuser = {out_result.clear_screen, out_result.write_valid};

endmodule

`default_nettype wire

@@ sv/ctc_cursor.sv @@
`default_nettype none

// Cursor state and next-cursor logic for one character
module ctc_cursor #(
    parameter int COLUMNS = ctc_pkg::COLUMNS_DEF,
    parameter int ROWS    = ctc_pkg::ROWS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [ctc_pkg::CHAR_W-1:0]  i_char,
    input  wire logic [ctc_pkg::ATTR_W-1:0]  i_attr,
    output ctc_pkg::t_result                 o_result
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int LIN_S = ROW_W + COL_W + 1;
    localparam int LIN_W = (LIN_S > ctc_pkg::ADDR_W) ? LIN_S : ctc_pkg::ADDR_W;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [COL_W:0]   col_w;
    logic [ROW_W:0]   row_w;
    logic             wvalid;
    logic             clear;
    logic [LIN_W-1:0] cur_lin;
    logic [LIN_W-1:0] new_lin;

    // cursor move for this character
    always_comb begin
        col_w  = {1'b0, r_col};
        row_w  = {1'b0, r_row};
        wvalid = 1'b0;
        clear  = 1'b0;
        case (i_char)
            ctc_pkg::CH_BACKSPACE: begin
                if (r_col != '0) col_w = col_w - (COL_W+1)'(1);
            end
            ctc_pkg::CH_TAB: begin
                col_w = col_w + (COL_W+1)'(ctc_pkg::TAB_STEP);
            end
            ctc_pkg::CH_RETURN: begin
                col_w = '0;
            end
            ctc_pkg::CH_LINEFEED: begin
                col_w = '0;
                row_w = row_w + (ROW_W+1)'(1);
            end
            default: begin
                if (i_char inside {[ctc_pkg::CH_FIRST_PRINT:ctc_pkg::CH_LAST_PRINT]}) begin
                    wvalid = 1'b1;
                    col_w  = col_w + (COL_W+1)'(1);
                end
            end
        endcase
        // wrap at the right edge
        if (col_w >= (COL_W+1)'(COLUMNS)) begin
            col_w = '0;
            row_w = row_w + (ROW_W+1)'(1);
        end
        // past the bottom: clear and home
        if (row_w >= (ROW_W+1)'(ROWS)) begin
            clear = 1'b1;
            col_w = '0;
            row_w = '0;
        end
        n_col = col_w[COL_W-1:0];
        n_row = row_w[ROW_W-1:0];
    end

    // linear addresses, old and new cursor
    assign cur_lin = LIN_W'(r_row) * LIN_W'(COLUMNS) + LIN_W'(r_col);
    assign new_lin = LIN_W'(n_row) * LIN_W'(COLUMNS) + LIN_W'(n_col);

    always_comb begin
        o_result.write_valid   = wvalid;
        o_result.write_address = wvalid ? cur_lin[ctc_pkg::ADDR_W-1:0] : '0;
        o_result.write_data    = wvalid ? {i_attr, i_char} : '0;
        o_result.clear_screen  = clear;
        o_result.cursor_pos    = new_lin[ctc_pkg::ADDR_W-1:0];
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ sv/ctc_out_reg.sv @@
`default_nettype none

// Result register; takes a new word while empty or while the held one is being taken
module ctc_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ctc_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ctc_pkg::t_result      o_result
);

    logic             r_valid;
    ctc_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire
